@@ rtl/gfnv_pkg.sv @@
package gfnv_pkg;

  // default channel width of the texel fields
  localparam int CHANNEL_BITS_DEF = 16;

  // fixed-point formats of the internal datapath
  localparam int Q_BITS   = 32;  // fraction bits of the q.32 values
  localparam int LEN_BITS = 16;  // vector length in q.16
  localparam int T_BITS   = 18;  // (3 - l^2) in q.16
  localparam int DEN_BITS = 35;  // 2 * l * (3 - l^2), q.32

  localparam logic [Q_BITS:0]   ONE_Q32  = {1'b1, {Q_BITS{1'b0}}};
  localparam logic [Q_BITS-1:0] SQ_FLOOR = Q_BITS'(4);
  localparam logic [LEN_BITS-1:0] LEN_FLOOR = LEN_BITS'(2);

endpackage

@@ rtl/gfnv_isqrt.sv @@
module gfnv_isqrt #(
  parameter int IN_W   = 32,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int STEPS = IN_W / 2;
  localparam int RW    = STEPS + 2;

  logic [IN_W-1:0]   x_r    [STEPS];
  logic [RW-1:0]     rem_r  [STEPS];
  logic [STEPS-1:0]  root_r [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];
  logic              v_r    [STEPS];

  logic [IN_W-1:0]   x_n    [STEPS];
  logic [RW-1:0]     rem_n  [STEPS];
  logic [STEPS-1:0]  root_n [STEPS];

  // one result bit per stage, restoring
  always_comb begin
    logic [IN_W-1:0]  xin;
    logic [RW-1:0]    rin;
    logic [STEPS-1:0] qin;
    logic [RW-1:0]    cur;
    logic [RW-1:0]    trial;
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        xin = radicand;
        rin = '0;
        qin = '0;
      end else begin
        xin = x_r[k-1];
        rin = rem_r[k-1];
        qin = root_r[k-1];
      end
      cur   = {rin[RW-3:0], xin[IN_W-1 -: 2]};
      trial = {qin, 2'b01};
      x_n[k] = xin << 2;
      if (cur >= trial) begin
        rem_n[k]  = cur - trial;
        root_n[k] = {qin[STEPS-2:0], 1'b1};
      end else begin
        rem_n[k]  = cur;
        root_n[k] = {qin[STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STEPS; k++) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
      if (en) begin
        x_r[k]    <= x_n[k];
        rem_r[k]  <= rem_n[k];
        root_r[k] <= root_n[k];
        side_r[k] <= (k == 0) ? side_in : side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign root      = root_r[STEPS-1];
  assign side_out  = side_r[STEPS-1];

endmodule

@@ rtl/gfnv_div.sv @@
module gfnv_div #(
  parameter int DEN_W  = 35,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_r  [Q_W];
  logic [DEN_W-1:0]  den_r  [Q_W];
  logic [Q_W-1:0]    quot_r [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];
  logic              v_r    [Q_W];

  logic [DEN_W-1:0]  rem_n  [Q_W];
  logic [Q_W-1:0]    quot_n [Q_W];

  // fraction bits of num / den, num below den, one bit per stage
  always_comb begin
    logic [DEN_W-1:0] rin;
    logic [DEN_W-1:0] din;
    logic [Q_W-1:0]   qin;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   dd;
    logic [DEN_W:0]   diff;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        rin = num;
        din = den;
        qin = '0;
      end else begin
        rin = rem_r[k-1];
        din = den_r[k-1];
        qin = quot_r[k-1];
      end
      sh   = {rin, 1'b0};
      dd   = {1'b0, din};
      diff = sh - dd;
      if (sh >= dd) begin
        rem_n[k]  = diff[DEN_W-1:0];
        quot_n[k] = {qin[Q_W-2:0], 1'b1};
      end else begin
        rem_n[k]  = sh[DEN_W-1:0];
        quot_n[k] = {qin[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
      if (en) begin
        rem_r[k]  <= rem_n[k];
        quot_r[k] <= quot_n[k];
        den_r[k]  <= (k == 0) ? den : den_r[k-1];
        side_r[k] <= (k == 0) ? side_in : side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign quot      = quot_r[Q_W-1];
  assign side_out  = side_r[Q_W-1];

endmodule

@@ rtl/gloss_from_normal_variance_core.sv @@
// gloss from normal variance: one texel beat in, one smoothness beat out, in order.
// a filtered normal shorter than one turns into extra roughness: l = |n|,
// variance = (1-l^2)/(2l(3-l^2)), roughness' = min(sqrt(((1-s)^2)^2 + variance), 1),
// smoothness = 1 - sqrt(roughness'). a texel of length one or more passes the
// authored smoothness (or all ones when has_authored_gloss is clear) with derived
// low. the pipeline takes a texel every cycle that it advances. the bit-per-stage
// units are a 16 stage length sqrt, a 32 stage variance divider and two 32 stage
// sqrts, plus eight register stages around them, the output register included.
// the whole pipe advances when the output register is empty or taken, so a stall
// holds every stage and loses nothing.
module gloss_from_normal_variance_core #(
  parameter int CHANNEL_BITS = gfnv_pkg::CHANNEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // config: has_authored_gloss
  input  logic cfg_we,
  input  logic cfg_wdata,
  // s_tdata: normal_x, normal_y, normal_z, authored_smoothness
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
  // m_tdata: smoothness; m_tuser: derived
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
  output logic m_tuser
);
  import gfnv_pkg::*;

  localparam int C     = CHANNEL_BITS;
  localparam int OUT_W = ((C + 7) / 8) * 8;
  localparam int SH    = 34 - 2 * C;      // sum of squares to q.32
  localparam int DSH   = Q_BITS - C;      // q.32 down to the channel format
  localparam int SIDE1 = Q_BITS + C + 1;
  localparam int SIDE2 = (Q_BITS + 1) + 1 + C + 1;
  localparam int SIDE3 = 1 + C + 1;
  localparam logic [C-1:0] HALF = {1'b1, {(C-1){1'b0}}};
  localparam logic [C-1:0] MASK = {C{1'b1}};

  function automatic logic [C-1:0] cmag(input logic [C-1:0] c);
    logic [C-1:0] lo;
    lo = {1'b0, c[C-2:0]};
    return c[C-1] ? lo : HALF - c;
  endfunction

  // square of a q.32 value no greater than one
  function automatic logic [Q_BITS:0] square32(input logic [Q_BITS:0] a);
    logic [2*Q_BITS-1:0] p;
    p = a[Q_BITS-1:0] * a[Q_BITS-1:0];
    return a[Q_BITS] ? ONE_Q32 : {1'b0, p[2*Q_BITS-1:Q_BITS]};
  endfunction

  // config register, to be written by the user only while the pipe is empty; the block does not enforce this
  logic gloss_en;
  always_ff @(posedge clk) begin
    if (rst) begin
      gloss_en <= 1'b0;
    end else if (cfg_we) begin
      gloss_en <= cfg_wdata;
    end
  end

  // global advance: every stage moves when the output register can take a beat
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: centered channel magnitudes
  logic         v1;
  logic [C-1:0] ax1, ay1, az1, s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
    if (adv) begin
      ax1 <= cmag(s_tdata[C-1:0]);
      ay1 <= cmag(s_tdata[2*C-1:C]);
      az1 <= cmag(s_tdata[3*C-1:2*C]);
      s1  <= s_tdata[4*C-1:3*C];
    end
  end

  // stage 2: squares
  logic           v2;
  logic [2*C-1:0] sqx2, sqy2, sqz2;
  logic [C-1:0]   s2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      sqx2 <= ax1 * ax1;
      sqy2 <= ay1 * ay1;
      sqz2 <= az1 * az1;
      s2   <= s1;
    end
  end

  // stage 3: length squared in q.32, bypass flag, floor
  logic [2*C-1:0] sumsq;
  logic [33:0]    q34;
  assign sumsq = sqx2 + sqy2 + sqz2;
  generate
    if (SH >= 0) begin : g_shl
      assign q34 = 34'(sumsq) << SH;
    end else begin : g_shr
      assign q34 = 34'(sumsq >> (-SH));
    end
  endgenerate

  logic              v3, big3;
  logic [Q_BITS-1:0] q3;
  logic [C-1:0]      s3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      big3 <= |q34[33:32];
      q3   <= (q34[31:0] < SQ_FLOOR) ? SQ_FLOOR : q34[31:0];
      s3   <= s2;
    end
  end

  // length sqrt, q.32 -> q.16
  logic                v4;
  logic [LEN_BITS-1:0] l4;
  logic [SIDE1-1:0]    side4;
  gfnv_isqrt #(.IN_W(Q_BITS), .SIDE_W(SIDE1)) u_len_sqrt (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v3),
    .radicand(q3), .side_in({q3, s3, big3}),
    .out_valid(v4), .root(l4), .side_out(side4)
  );

  logic [Q_BITS-1:0] q4;
  logic [C-1:0]      s4;
  logic              big4;
  assign {q4, s4, big4} = side4;

  // stage 5: floor length, numerator, (3 - l^2) in q.16, 1 - s
  logic [Q_BITS:0]   s32_5;
  logic [33:0]       three_m;
  assign s32_5   = gloss_en ? (33'(s4) << DSH) : ONE_Q32;
  assign three_m = (34'(3) << Q_BITS) - 34'(q4);

  logic                v5, big5;
  logic [LEN_BITS-1:0] l5;
  logic [T_BITS-1:0]   t5;
  logic [Q_BITS-1:0]   num5;
  logic [Q_BITS:0]     a5;
  logic [C-1:0]        s5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      l5   <= (l4 < LEN_FLOOR) ? LEN_FLOOR : l4;
      t5   <= T_BITS'(three_m >> 16);
      num5 <= Q_BITS'(ONE_Q32 - 33'(q4));
      a5   <= ONE_Q32 - s32_5;
      s5   <= s4;
      big5 <= big4;
    end
  end

  // stage 6: l * (3 - l^2), roughness
  logic                       v6, big6;
  logic [LEN_BITS+T_BITS-1:0] dh6;
  logic [Q_BITS:0]            r6;
  logic [Q_BITS-1:0]          num6;
  logic [C-1:0]               s6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
    if (adv) begin
      dh6  <= l5 * t5;
      r6   <= square32(a5);
      num6 <= num5;
      s6   <= s5;
      big6 <= big5;
    end
  end

  // stage 7: denominator, quotient overflow, roughness squared
  logic [DEN_BITS-1:0] den6;
  assign den6 = DEN_BITS'({dh6, 1'b0});

  logic                v7, big7, ovf7;
  logic [DEN_BITS-1:0] den7, num7;
  logic [Q_BITS:0]     r27;
  logic [C-1:0]        s7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
    if (adv) begin
      den7 <= den6;
      num7 <= DEN_BITS'(num6);
      ovf7 <= DEN_BITS'(num6) >= den6;   // variance of one or more
      r27  <= square32(r6);
      s7   <= s6;
      big7 <= big6;
    end
  end

  // variance fraction bits
  logic              v8;
  logic [Q_BITS-1:0] vq8;
  logic [SIDE2-1:0]  side8;
  gfnv_div #(.DEN_W(DEN_BITS), .Q_W(Q_BITS), .SIDE_W(SIDE2)) u_var_div (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v7), .num(num7), .den(den7),
    .side_in({r27, ovf7, s7, big7}),
    .out_valid(v8), .quot(vq8), .side_out(side8)
  );

  logic [Q_BITS:0] r28;
  logic            ovf8, big8;
  logic [C-1:0]    s8;
  assign {r28, ovf8, s8, big8} = side8;

  // stage 9: roughness^2 + variance, saturate at one
  logic [Q_BITS+1:0] sum8;
  logic              sat8;
  assign sum8 = 34'(r28) + 34'(vq8);
  assign sat8 = ovf8 || (sum8 >= 34'(ONE_Q32));

  logic              v9, sat9, big9;
  logic [Q_BITS-1:0] x9;
  logic [C-1:0]      s9;
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
    if (adv) begin
      x9   <= sat8 ? '0 : sum8[Q_BITS-1:0];
      sat9 <= sat8;
      s9   <= s8;
      big9 <= big8;
    end
  end

  // two q.32 square roots in a row
  logic              v10, v11;
  logic [Q_BITS-1:0] rt10, rt11;
  logic [SIDE3-1:0]  side10, side11;
  gfnv_isqrt #(.IN_W(2*Q_BITS), .SIDE_W(SIDE3)) u_rough_sqrt (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v9), .radicand({x9, {Q_BITS{1'b0}}}), .side_in({sat9, s9, big9}),
    .out_valid(v10), .root(rt10), .side_out(side10)
  );
  gfnv_isqrt #(.IN_W(2*Q_BITS), .SIDE_W(SIDE3)) u_smooth_sqrt (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(v10), .radicand({rt10, {Q_BITS{1'b0}}}), .side_in(side10),
    .out_valid(v11), .root(rt11), .side_out(side11)
  );

  logic         sat11, big11;
  logic [C-1:0] s11;
  assign {sat11, s11, big11} = side11;

  // final: 1 - root in channel format, saturated, bypass select
  logic [Q_BITS:0] root_full, diff, dsh;
  logic [C-1:0]    res, smooth_next;
  assign root_full = sat11 ? ONE_Q32 : {1'b0, rt11};
  assign diff      = ONE_Q32 - root_full;
  assign dsh       = diff >> DSH;
  assign res       = (dsh > 33'(MASK)) ? MASK : dsh[C-1:0];
  assign smooth_next = big11 ? (gloss_en ? s11 : MASK) : res;

  // output register parts the pipe from the sink
  logic [C-1:0] smooth_q;
  logic         derived_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v11;
    end
    if (adv) begin
      smooth_q  <= smooth_next;
      derived_q <= !big11;
    end
  end

  assign m_tdata = OUT_W'(smooth_q);
  assign m_tuser = derived_q;

  // a finished texel always lands in the output register
  a_land: assert property (@(posedge clk) disable iff (rst) v11 && adv |=> m_tvalid)
    else $error("finished texel not captured");

  // bypass without authored gloss gives full smoothness
  a_bypass: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tuser && !gloss_en |-> m_tdata[C-1:0] == MASK)
    else $error("bypass smoothness not all ones");

  // saturated roughness gives zero smoothness
  a_sat: assert property (@(posedge clk) disable iff (rst)
      v11 && adv && !big11 && sat11 |=> m_tdata[C-1:0] == '0)
    else $error("saturated roughness not zero smoothness");

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
